// ===== rtl/lavm_pkg.sv =====
package lavm_pkg;

	localparam int FRAC_BITS = 16;
	localparam int IN_W = 32;
	localparam int UNIT_W = 18;
	localparam int SHIFT_W = 32;
	localparam int S_DATA_W = 288;
	localparam int M_DATA_W = 264;
	localparam int NORM_TOP = 30;
	localparam int ROOT_STEPS = 32;

endpackage

// ===== rtl/look_at_view_matrix_unit.sv =====
// throughput: one item per cycle while the result side does not stall,
// set by the fully pipelined root and divide stages
// the two normalizers hold 32 root stages and FRAC_BITS+1 divide stages each
// a stall on the result side freezes every stage at once
// reset clears the valid bits only, the data registers keep their contents
module look_at_view_matrix_unit #(
	parameter int FRAC_BITS = lavm_pkg::FRAC_BITS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// eye_x, eye_y, eye_z, target_x, target_y, target_z, up_x, up_y, up_z
	input  logic [lavm_pkg::S_DATA_W-1:0] s_tdata,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// right_x, right_y, right_z, camera_up_x, camera_up_y, camera_up_z,
	// back_x, back_y, back_z, shift_x, shift_y, shift_z, zero fill
	output logic [lavm_pkg::M_DATA_W-1:0] m_tdata
);

	localparam int F = FRAC_BITS;
	localparam int IW = lavm_pkg::IN_W;
	localparam int UNW = lavm_pkg::UNIT_W;
	localparam int SHW = lavm_pkg::SHIFT_W;
	localparam int UW = F + 2;
	localparam int DIW = IW + 1;
	localparam int RCW = IW + UW + 1;
	localparam int CUW = 2 * UW + 1;
	localparam int P2 = UW + IW;
	localparam int DW = P2 + 2;
	localparam int SW1 = 6 * IW;
	localparam int SW2 = 3 * UW + 3 * IW;
	localparam int SW3 = 6 * UW + 3 * IW;
	localparam int PADW = lavm_pkg::M_DATA_W - 9 * UNW - 3 * SHW;
	localparam logic [CUW-1:0] HALF_C = CUW'(1) << (F - 1);
	localparam logic [CUW-1:0] LIM_C = CUW'(1) << F;
	localparam logic [DW-1:0] HALF_D = DW'(1) << (F - 1);
	localparam logic [DW-1:0] POS_LIM = DW'({1'b0, {(SHW-1){1'b1}}});
	localparam logic [DW-1:0] NEG_LIM = DW'({1'b1, {(SHW-1){1'b0}}});
	localparam logic [UW-1:0] UONE = UW'(1) << F;

	logic                  en;
	logic                  vin_q;
	logic [5:0]            vt_q;
	logic [2:0][DIW-1:0]   diff_s1;
	logic [2:0][IW-1:0]    eye_s1;
	logic [2:0][IW-1:0]    up_s1;

	logic                  n1_valid;
	logic [2:0][UW-1:0]    n1_back;
	logic [SW1-1:0]        n1_side;
	logic [2:0][IW-1:0]    n1_up;
	logic [2:0][IW-1:0]    n1_eye;

	logic                  c1_valid;
	logic [2:0][RCW-1:0]   c1_r;
	logic [SW2-1:0]        c1_side;

	logic                  n2_valid;
	logic [2:0][UW-1:0]    n2_right;
	logic [SW2-1:0]        n2_side;
	logic [2:0][UW-1:0]    n2_back;
	logic [2:0][IW-1:0]    n2_eye;

	logic                  c2_valid;
	logic [2:0][CUW-1:0]   c2_cu;
	logic [SW3-1:0]        c2_side;

	logic [2:0][CUW-1:0]   cmg;
	logic [2:0][CUW-1:0]   cmg_s2;
	logic [2:0]            cng_s2;
	logic [2:0][UW-1:0]    rt_s2, bk_s2;
	logic [2:0][IW-1:0]    eye_s2;
	logic [2:0][UW-1:0]    cu_s3, rt_s3, bk_s3;
	logic [2:0][IW-1:0]    eye_s3;
	logic [8:0][P2-1:0]    prd_s4;
	logic [2:0][UW-1:0]    cu_s4, rt_s4, bk_s4;
	logic [2:0][DW-1:0]    dot_s5;
	logic [2:0][UW-1:0]    cu_s5, rt_s5, bk_s5;
	logic [2:0][DW-1:0]    dmg;
	logic [2:0][DW-1:0]    dmg_s6;
	logic [2:0]            dng_s6;
	logic [2:0][UW-1:0]    cu_s6, rt_s6, bk_s6;
	logic [2:0][SHW-1:0]   sh_s7;
	logic [2:0][UW-1:0]    cu_s7, rt_s7, bk_s7;
	logic [2:0][UNW-1:0]   rt_o, cu_o, bk_o;

	assign en = !m_tvalid || m_tready;
	assign s_tready = en;
	assign m_tvalid = vt_q[5];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vin_q <= 1'b0;
			vt_q <= '0;
		end else if (en) begin
			vin_q <= s_tvalid;
			vt_q <= {vt_q[4:0], c2_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				eye_s1[i] <= s_tdata[IW*i +: IW];
				up_s1[i] <= s_tdata[IW*(6+i) +: IW];
				diff_s1[i] <= DIW'($signed(s_tdata[IW*i +: IW]))
					- DIW'($signed(s_tdata[IW*(3+i) +: IW]));
			end
		end
	end

	lavm_norm #(
		.W  (DIW),
		.SW (SW1),
		.F  (F)
	) u_norm_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (vin_q),
		.v         (diff_s1),
		.side      ({up_s1, eye_s1}),
		.out_valid (n1_valid),
		.u         (n1_back),
		.side_out  (n1_side)
	);

	assign n1_up = n1_side[SW1-1:3*IW];
	assign n1_eye = n1_side[3*IW-1:0];

	lavm_cross #(
		.AW (IW),
		.BW (UW),
		.SW (SW2)
	) u_cross_right (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (n1_valid),
		.a         (n1_up),
		.b         (n1_back),
		.side      ({n1_back, n1_eye}),
		.out_valid (c1_valid),
		.r         (c1_r),
		.side_out  (c1_side)
	);

	lavm_norm #(
		.W  (RCW),
		.SW (SW2),
		.F  (F)
	) u_norm_right (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (c1_valid),
		.v         (c1_r),
		.side      (c1_side),
		.out_valid (n2_valid),
		.u         (n2_right),
		.side_out  (n2_side)
	);

	assign n2_back = n2_side[SW2-1:3*IW];
	assign n2_eye = n2_side[3*IW-1:0];

	lavm_cross #(
		.AW (UW),
		.BW (UW),
		.SW (SW3)
	) u_cross_up (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (n2_valid),
		.a         (n2_back),
		.b         (n2_right),
		.side      ({n2_right, n2_back, n2_eye}),
		.out_valid (c2_valid),
		.r         (c2_cu),
		.side_out  (c2_side)
	);

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			cmg[i] = c2_cu[i][CUW-1] ? CUW'(-$signed(c2_cu[i])) : c2_cu[i];
			dmg[i] = dot_s5[i][DW-1] ? DW'(-$signed(dot_s5[i])) : dot_s5[i];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// camera up: round half away from zero, then clamp
			for (int i = 0; i < 3; i++) begin
				cmg_s2[i] <= (cmg[i] + HALF_C) >> F;
				cng_s2[i] <= c2_cu[i][CUW-1];
			end
			rt_s2 <= c2_side[SW3-1:3*UW+3*IW];
			bk_s2 <= c2_side[3*UW+3*IW-1:3*IW];
			eye_s2 <= c2_side[3*IW-1:0];

			for (int i = 0; i < 3; i++) begin
				if (cmg_s2[i] > LIM_C) begin
					cu_s3[i] <= cng_s2[i] ? UW'(-LIM_C) : UW'(LIM_C);
				end else begin
					cu_s3[i] <= cng_s2[i] ? UW'(-cmg_s2[i]) : UW'(cmg_s2[i]);
				end
			end
			rt_s3 <= rt_s2;
			bk_s3 <= bk_s2;
			eye_s3 <= eye_s2;

			for (int i = 0; i < 3; i++) begin
				prd_s4[i] <= P2'($signed(rt_s3[i])) * P2'($signed(eye_s3[i]));
				prd_s4[3+i] <= P2'($signed(cu_s3[i])) * P2'($signed(eye_s3[i]));
				prd_s4[6+i] <= P2'($signed(bk_s3[i])) * P2'($signed(eye_s3[i]));
			end
			cu_s4 <= cu_s3;
			rt_s4 <= rt_s3;
			bk_s4 <= bk_s3;

			for (int a = 0; a < 3; a++) begin
				dot_s5[a] <= DW'($signed(prd_s4[3*a])) + DW'($signed(prd_s4[3*a+1]))
					+ DW'($signed(prd_s4[3*a+2]));
			end
			cu_s5 <= cu_s4;
			rt_s5 <= rt_s4;
			bk_s5 <= bk_s4;

			for (int a = 0; a < 3; a++) begin
				dmg_s6[a] <= (dmg[a] + HALF_D) >> F;
				dng_s6[a] <= dot_s5[a][DW-1];
			end
			cu_s6 <= cu_s5;
			rt_s6 <= rt_s5;
			bk_s6 <= bk_s5;

			// negate and saturate the translation
			for (int a = 0; a < 3; a++) begin
				if (dng_s6[a]) begin
					sh_s7[a] <= (dmg_s6[a] > POS_LIM) ? {1'b0, {(SHW-1){1'b1}}}
						: SHW'(dmg_s6[a]);
				end else begin
					sh_s7[a] <= (dmg_s6[a] > NEG_LIM) ? {1'b1, {(SHW-1){1'b0}}}
						: SHW'(-dmg_s6[a]);
				end
			end
			cu_s7 <= cu_s6;
			rt_s7 <= rt_s6;
			bk_s7 <= bk_s6;
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			rt_o[i] = UNW'($signed(rt_s7[i]));
			cu_o[i] = UNW'($signed(cu_s7[i]));
			bk_o[i] = UNW'($signed(bk_s7[i]));
		end
	end

	assign m_tdata = {PADW'(0), sh_s7, bk_o, cu_o, rt_o};

	a_zero_back: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && bk_s7 == '0) |-> (rt_s7 == '0 && cu_s7 == '0))
		else $error("zero back axis with nonzero right or camera up");

	a_zero_right: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && rt_s7 == '0) |-> (cu_s7 == '0))
		else $error("zero right axis with nonzero camera up");

	a_cu_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ($signed(cu_s7[0]) <= $signed(UONE) && $signed(cu_s7[0]) >= -$signed(UONE)
		&& $signed(cu_s7[1]) <= $signed(UONE) && $signed(cu_s7[1]) >= -$signed(UONE)
		&& $signed(cu_s7[2]) <= $signed(UONE) && $signed(cu_s7[2]) >= -$signed(UONE)))
		else $error("camera up outside clamp range");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> ($stable(vt_q) && $stable(vin_q)))
		else $error("pipeline valid moved during stall");

endmodule

// ===== rtl/lavm_cross.sv =====
module lavm_cross #(
	parameter int AW = 32,
	parameter int BW = 18,
	parameter int SW = 1
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       en,
	input  logic                       in_valid,
	input  logic [2:0][AW-1:0]         a,
	input  logic [2:0][BW-1:0]         b,
	input  logic [SW-1:0]              side,
	output logic                       out_valid,
	output logic [2:0][AW+BW:0]        r,
	output logic [SW-1:0]              side_out
);

	localparam int PW = AW + BW;
	localparam int RW = PW + 1;

	logic [1:0]          vld_q;
	logic [5:0][PW-1:0]  prd_s1;
	logic [SW-1:0]       side_s1;
	logic [2:0][RW-1:0]  r_s2;
	logic [SW-1:0]       side_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prd_s1[0] <= PW'($signed(a[1])) * PW'($signed(b[2]));
			prd_s1[1] <= PW'($signed(a[2])) * PW'($signed(b[1]));
			prd_s1[2] <= PW'($signed(a[2])) * PW'($signed(b[0]));
			prd_s1[3] <= PW'($signed(a[0])) * PW'($signed(b[2]));
			prd_s1[4] <= PW'($signed(a[0])) * PW'($signed(b[1]));
			prd_s1[5] <= PW'($signed(a[1])) * PW'($signed(b[0]));
			side_s1 <= side;
			r_s2[0] <= RW'($signed(prd_s1[0])) - RW'($signed(prd_s1[1]));
			r_s2[1] <= RW'($signed(prd_s1[2])) - RW'($signed(prd_s1[3]));
			r_s2[2] <= RW'($signed(prd_s1[4])) - RW'($signed(prd_s1[5]));
			side_s2 <= side_s1;
		end
	end

	assign out_valid = vld_q[1];
	assign r = r_s2;
	assign side_out = side_s2;

endmodule

// ===== rtl/lavm_norm.sv =====
module lavm_norm #(
	parameter int W = 33,
	parameter int SW = 1,
	parameter int F = lavm_pkg::FRAC_BITS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 in_valid,
	input  logic [2:0][W-1:0]    v,
	input  logic [SW-1:0]        side,
	output logic                 out_valid,
	output logic [2:0][F+1:0]    u,
	output logic [SW-1:0]        side_out
);

	localparam int TOP = lavm_pkg::NORM_TOP;
	localparam int MB = TOP + 1;
	localparam int NR = $clog2(W - TOP);
	localparam int NL = $clog2(MB);
	localparam int RS = lavm_pkg::ROOT_STEPS;
	localparam int RN = 2 * RS;
	localparam int CW = SW + 4;
	localparam int NW = MB + 1 + F;
	localparam int QW = F + 1;
	localparam int UW = F + 2;
	localparam int D = 1 + NR + NL + 2 + RS + QW + 1;

	typedef struct packed {
		logic [2:0][W-1:0] m;
		logic [W-1:0]      t;
		logic [CW-1:0]     c;
	} rsh_t;

	typedef struct packed {
		logic [2:0][MB-1:0] m;
		logic [MB-1:0]      t;
		logic [CW-1:0]      c;
	} lsh_t;

	typedef struct packed {
		logic [2:0][2*MB-1:0] sq;
		logic [2:0][MB-1:0]   m;
		logic [CW-1:0]        c;
	} sqr_t;

	typedef struct packed {
		logic [RN-1:0]      n;
		logic [RN-1:0]      r;
		logic [2:0][MB-1:0] m;
		logic [CW-1:0]      c;
	} root_t;

	typedef struct packed {
		logic [2:0][NW-1:0] rem;
		logic [2:0][QW-1:0] q;
		logic [RS-1:0]      len;
		logic [CW-1:0]      c;
	} div_t;

	logic [D-1:0]       vld_q;
	logic [2:0][W-1:0]  mg;
	logic [W-1:0]       tp01;
	logic [W-1:0]       tp;
	rsh_t               rsh_s1 [0:NR];
	lsh_t               lsh_s2 [0:NL-1];
	sqr_t               sqr_s3;
	root_t              sum_s4;
	root_t              root_s5 [0:RS-1];
	div_t               div_s6 [0:QW-1];
	logic [2:0][UW-1:0] u_s7;
	logic [SW-1:0]      side_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[D-2:0], in_valid};
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			mg[i] = v[i][W-1] ? W'(-$signed(v[i])) : v[i];
		end
		tp01 = (mg[0] > mg[1]) ? mg[0] : mg[1];
		tp = (tp01 > mg[2]) ? tp01 : mg[2];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rsh_s1[0].m <= mg;
			rsh_s1[0].t <= tp;
			rsh_s1[0].c <= {side, v[2][W-1], v[1][W-1], v[0][W-1], (tp == '0)};
		end
	end

	for (genvar k = 0; k < NR; k++) begin : g_rsh
		localparam int S = 1 << (NR - 1 - k);
		always_ff @(posedge clk) begin
			if (en) begin
				rsh_s1[k+1].c <= rsh_s1[k].c;
				if (rsh_s1[k].t[W-1:TOP+S] != '0) begin
					rsh_s1[k+1].t <= rsh_s1[k].t >> S;
					for (int i = 0; i < 3; i++) begin
						rsh_s1[k+1].m[i] <= rsh_s1[k].m[i] >> S;
					end
				end else begin
					rsh_s1[k+1].t <= rsh_s1[k].t;
					rsh_s1[k+1].m <= rsh_s1[k].m;
				end
			end
		end
	end

	for (genvar k = 0; k < NL; k++) begin : g_lsh
		localparam int S = 1 << (NL - 1 - k);
		lsh_t src;
		if (k == 0) begin : g_first
			always_comb begin
				for (int i = 0; i < 3; i++) begin
					src.m[i] = rsh_s1[NR].m[i][MB-1:0];
				end
				src.t = rsh_s1[NR].t[MB-1:0];
				src.c = rsh_s1[NR].c;
			end
		end else begin : g_next
			assign src = lsh_s2[k-1];
		end
		always_ff @(posedge clk) begin
			if (en) begin
				lsh_s2[k].c <= src.c;
				if (src.t[MB-1:MB-S] == '0) begin
					lsh_s2[k].t <= src.t << S;
					for (int i = 0; i < 3; i++) begin
						lsh_s2[k].m[i] <= src.m[i] << S;
					end
				end else begin
					lsh_s2[k].t <= src.t;
					lsh_s2[k].m <= src.m;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				sqr_s3.sq[i] <= (2*MB)'(lsh_s2[NL-1].m[i]) * (2*MB)'(lsh_s2[NL-1].m[i]);
			end
			sqr_s3.m <= lsh_s2[NL-1].m;
			sqr_s3.c <= lsh_s2[NL-1].c;
			sum_s4.n <= RN'(sqr_s3.sq[0]) + RN'(sqr_s3.sq[1]) + RN'(sqr_s3.sq[2]);
			sum_s4.r <= '0;
			sum_s4.m <= sqr_s3.m;
			sum_s4.c <= sqr_s3.c;
		end
	end

	// one result bit per stage, bit walks down two places at a time
	for (genvar k = 0; k < RS; k++) begin : g_root
		localparam logic [RN-1:0] B = RN'(1) << (RN - 2 - 2 * k);
		root_t         src;
		logic [RN-1:0] trial;
		if (k == 0) begin : g_first
			assign src = sum_s4;
		end else begin : g_next
			assign src = root_s5[k-1];
		end
		assign trial = src.r + B;
		always_ff @(posedge clk) begin
			if (en) begin
				root_s5[k].m <= src.m;
				root_s5[k].c <= src.c;
				if (src.n >= trial) begin
					root_s5[k].n <= src.n - trial;
					root_s5[k].r <= (src.r >> 1) + B;
				end else begin
					root_s5[k].n <= src.n;
					root_s5[k].r <= src.r >> 1;
				end
			end
		end
	end

	// restoring division, one quotient bit per stage
	for (genvar k = 0; k < QW; k++) begin : g_div
		localparam int P = QW - 1 - k;
		div_t          src;
		logic [NW-1:0] dd;
		if (k == 0) begin : g_first
			always_comb begin
				src.len = root_s5[RS-1].r[RS-1:0];
				for (int i = 0; i < 3; i++) begin
					src.rem[i] = (NW'(root_s5[RS-1].m[i]) << F) + NW'(src.len >> 1);
				end
				src.q = '0;
				src.c = root_s5[RS-1].c;
			end
		end else begin : g_next
			assign src = div_s6[k-1];
		end
		assign dd = NW'(src.len) << P;
		always_ff @(posedge clk) begin
			if (en) begin
				div_s6[k].len <= src.len;
				div_s6[k].c <= src.c;
				for (int i = 0; i < 3; i++) begin
					if (src.rem[i] >= dd) begin
						div_s6[k].rem[i] <= src.rem[i] - dd;
						div_s6[k].q[i] <= src.q[i] | (QW'(1) << P);
					end else begin
						div_s6[k].rem[i] <= src.rem[i];
						div_s6[k].q[i] <= src.q[i];
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				if (div_s6[QW-1].c[0]) begin
					u_s7[i] <= '0;
				end else if (div_s6[QW-1].c[1+i]) begin
					u_s7[i] <= UW'(-{1'b0, div_s6[QW-1].q[i]});
				end else begin
					u_s7[i] <= {1'b0, div_s6[QW-1].q[i]};
				end
			end
			side_s7 <= div_s6[QW-1].c[CW-1:4];
		end
	end

	assign out_valid = vld_q[D-1];
	assign u = u_s7;
	assign side_out = side_s7;

endmodule

// ===== tb/look_at_view_matrix_unit_tb.sv =====
module look_at_view_matrix_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int FRAC_BITS = lavm_pkg::FRAC_BITS;
	localparam int UNIT_W = lavm_pkg::UNIT_W;
	localparam int S_DATA_W = lavm_pkg::S_DATA_W;
	localparam int M_DATA_W = lavm_pkg::M_DATA_W;

	localparam int LIMIT_CYCLES = 600000;
	localparam int RANDOM_ITEMS = 1450;

	class view_scoreboard;
		bit [M_DATA_W-1:0] pending[$];
		int fails;
		string names[12] = '{"right_x", "right_y", "right_z", "camera_up_x", "camera_up_y",
			"camera_up_z", "back_x", "back_y", "back_z", "shift_x", "shift_y", "shift_z"};

		function automatic longint unsigned mag(longint v);
			return v < 0 ? longint'(0) - v : v;
		endfunction

		function automatic longint round_frac(longint v);
			longint unsigned m;
			m = (mag(v) + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
			return v < 0 ? -longint'(m) : longint'(m);
		endfunction

		function automatic longint unsigned root(longint unsigned n);
			longint unsigned res, b;
			res = 0;
			b = 64'd1 << 62;
			while (b > n) b >>= 2;
			while (b != 0) begin
				if (n >= res + b) begin
					n -= res + b;
					res = (res >> 1) + b;
				end else begin
					res >>= 1;
				end
				b >>= 2;
			end
			return res;
		endfunction

		function automatic void unit_vec(input longint v[3], output longint u[3]);
			longint unsigned m[3], top, sum, len, q;
			top = 0;
			sum = 0;
			for (int i = 0; i < 3; i++) begin
				m[i] = mag(v[i]);
				if (m[i] > top) top = m[i];
			end
			if (top == 0) begin
				u = '{0, 0, 0};
				return;
			end
			while (top >= (64'd1 << 31)) begin
				top >>= 1;
				for (int i = 0; i < 3; i++) m[i] >>= 1;
			end
			while (top < (64'd1 << 30)) begin
				top <<= 1;
				for (int i = 0; i < 3; i++) m[i] <<= 1;
			end
			for (int i = 0; i < 3; i++) sum += m[i] * m[i];
			len = root(sum);
			for (int i = 0; i < 3; i++) begin
				q = ((m[i] << FRAC_BITS) + (len >> 1)) / len;
				u[i] = v[i] < 0 ? -longint'(q) : longint'(q);
			end
		endfunction

		function automatic void cross_vec(input longint a[3], input longint b[3],
			output longint r[3]);
			r[0] = a[1] * b[2] - a[2] * b[1];
			r[1] = a[2] * b[0] - a[0] * b[2];
			r[2] = a[0] * b[1] - a[1] * b[0];
		endfunction

		function automatic bit [31:0] shift_term(input longint a[3], input longint e[3]);
			longint r;
			r = -round_frac(a[0] * e[0] + a[1] * e[1] + a[2] * e[2]);
			if (r > 64'sd2147483647) r = 64'sd2147483647;
			if (r < -64'sd2147483648) r = -64'sd2147483648;
			return r[31:0];
		endfunction

		function automatic void note(bit [S_DATA_W-1:0] d);
			longint eye[3], tgt[3], upw[3], diff[3], back[3], rc[3], right[3], cu[3];
			longint lim;
			bit [M_DATA_W-1:0] x;
			lim = 64'sd1 <<< FRAC_BITS;
			for (int i = 0; i < 3; i++) begin
				eye[i] = longint'($signed(d[32*i +: 32]));
				tgt[i] = longint'($signed(d[32*(3+i) +: 32]));
				upw[i] = longint'($signed(d[32*(6+i) +: 32]));
				diff[i] = eye[i] - tgt[i];
			end
			unit_vec(diff, back);
			cross_vec(upw, back, rc);
			unit_vec(rc, right);
			cross_vec(back, right, cu);
			for (int i = 0; i < 3; i++) begin
				cu[i] = round_frac(cu[i]);
				if (cu[i] > lim) cu[i] = lim;
				if (cu[i] < -lim) cu[i] = -lim;
			end
			x = '0;
			for (int i = 0; i < 3; i++) begin
				x[UNIT_W*i +: UNIT_W] = right[i][UNIT_W-1:0];
				x[UNIT_W*(3+i) +: UNIT_W] = cu[i][UNIT_W-1:0];
				x[UNIT_W*(6+i) +: UNIT_W] = back[i][UNIT_W-1:0];
			end
			x[9*UNIT_W +: 32] = shift_term(right, eye);
			x[9*UNIT_W+32 +: 32] = shift_term(cu, eye);
			x[9*UNIT_W+64 +: 32] = shift_term(back, eye);
			pending.push_back(x);
		endfunction

		function automatic void check(bit [M_DATA_W-1:0] got);
			bit [M_DATA_W-1:0] want;
			bit [31:0] w, g;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result item %h", $time, got);
				fails++;
				return;
			end
			want = pending.pop_front();
			for (int i = 0; i < 12; i++) begin
				if (i < 9) begin
					w = 32'(want[UNIT_W*i +: UNIT_W]);
					g = 32'(got[UNIT_W*i +: UNIT_W]);
				end else begin
					w = want[9*UNIT_W+32*(i-9) +: 32];
					g = got[9*UNIT_W+32*(i-9) +: 32];
				end
				if (w !== g) begin
					$display("%0t: %s expected %h actual %h", $time, names[i], w, g);
					fails++;
				end
			end
			if (got[M_DATA_W-1:9*UNIT_W+96] !== '0) begin
				$display("%0t: fill expected 0 actual %h", $time,
					got[M_DATA_W-1:9*UNIT_W+96]);
				fails++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [S_DATA_W-1:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [M_DATA_W-1:0] m_tdata;

	view_scoreboard sb = new();
	bit calm;
	int cycles;

	look_at_view_matrix_unit u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT_CYCLES) begin
			$display("look_at_view_matrix_unit_tb failed");
			$finish;
		end
	end

	task automatic send_view(input int v[9]);
		int gap;
		bit [S_DATA_W-1:0] d;
		for (int i = 0; i < 9; i++) d[32*i +: 32] = v[i];
		gap = calm ? 0 : $urandom_range(0, 19);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= d;
		do @(posedge clk); while (!s_tready);
		sb.note(d);
	endtask

	function automatic int coord(bit wide);
		return wide ? int'($urandom) : $signed($urandom_range(0, 32'h0040_0000)) - 32'h0020_0000;
	endfunction

	initial begin
		int one, v[9];
		one = 1 << FRAC_BITS;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// eye on target, zero up, up along back, extremes, opposite corners
		send_view('{0, 0, 0, 0, 0, 0, 0, one, 0});
		send_view('{one, 2*one, 3*one, one, 2*one, 3*one, 0, one, 0});
		send_view('{0, 0, 5*one, 0, 0, 0, 0, 0, 0});
		send_view('{0, 0, 5*one, 0, 0, 0, 0, 0, one});
		send_view('{0, 3*one, 0, 0, 0, 0, 0, -7*one, 0});
		send_view('{0, 0, 5*one, 0, 0, 0, 0, one, 0});
		send_view('{3*one, 4*one, 5*one, 0, 0, 0, 0, one, 0});
		send_view('{32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
			32'h80000000, 32'h80000000, 32'h80000000, 0, one, 0});
		send_view('{32'h80000000, 32'h80000000, 32'h80000000,
			32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h80000000, 1});
		send_view('{32'h7fffffff, 32'h80000000, 32'h7fffffff,
			0, 0, 0, 32'h80000000, 32'h80000000, 32'h80000000});
		send_view('{32'h7fffffff, 0, 0, 32'h80000000, 0, 0, 0, 32'h7fffffff, 0});
		send_view('{1, 0, 0, 0, 0, 0, 0, 1, 0});
		send_view('{1, 1, 1, 0, 0, 0, -1, 1, 0});
		send_view('{-1, -1, -1, 0, 0, 1, 1, 0, 0});
		send_view('{32'hffffffff, 32'hffffffff, 32'hffffffff, 0, 0, 0, 0, 0, 32'hffffffff});
		send_view('{32'h12345678, 32'hedcba987, 32'h55555555,
			32'haaaaaaaa, 32'h0f0f0f0f, 32'hf0f0f0f0, 32'h33333333, 32'hcccccccc, 32'h1});
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			int kind;
			if (n % 150 == 0) calm = ($urandom_range(0, 2) == 0);
			kind = $urandom_range(0, 9);
			for (int i = 0; i < 9; i++) v[i] = coord(kind >= 7);
			if (kind == 0) for (int i = 0; i < 3; i++) v[3+i] = v[i];
			if (kind == 1) for (int i = 0; i < 3; i++) v[6+i] = v[i] - v[3+i];
			if (kind == 2) for (int i = 0; i < 3; i++) v[6+i] = 0;
			send_view(v);
		end
		s_tvalid <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (sb.fails == 0) begin
			$display("look_at_view_matrix_unit_tb passed");
		end else begin
			$display("look_at_view_matrix_unit_tb failed");
		end
		$finish;
	end

	initial begin
		int stall;
		@(posedge arst_n);
		forever begin
			stall = calm ? 0 : $urandom_range(0, 19);
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			sb.check(m_tdata);
		end
	end

endmodule

// ===== filelist.f =====
rtl/lavm_pkg.sv
rtl/lavm_cross.sv
rtl/lavm_norm.sv
rtl/look_at_view_matrix_unit.sv
tb/look_at_view_matrix_unit_tb.sv
